[rtl/core/lrtr_pkg.sv]
// ----------------------------------------------------------------------------
// lrtr_pkg: shared types and constants of the LED ring tiling remap
// Request and result payloads, ring settings layout, command queue entry
// and the request and register codes used across the block.
// ----------------------------------------------------------------------------
package lrtr_pkg;

    localparam int MAX_RINGS_DEF = 64;
    localparam int RING_LEDS     = 24;
    localparam int LAST_SLOT     = 23;
    localparam int CMD_DEPTH     = 4;
    localparam int OUT_DEPTH     = 4;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 8;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_SETTINGS = 2'd0;
    localparam logic [1:0] REQ_PIXEL    = 2'd1;
    localparam logic [1:0] REQ_EMIT     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_COUNT  = 4'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  ring;
        logic [10:0] render_index;
        logic        face;
        logic        winding;
        logic [4:0]  mount_offset;
        logic        extra_reverse;
        logic [4:0]  extra_offset;
        logic [8:0]  brightness;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } item_t;

    typedef struct packed {
        logic [10:0] pixel_index;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic        last_of_ring;
    } result_t;

    typedef struct packed {
        logic       face;
        logic       winding;
        logic [4:0] mount_offset;
        logic       extra_reverse;
        logic [4:0] extra_offset;
        logic [8:0] brightness;
    } ring_cfg_t;

    localparam ring_cfg_t RING_CFG_RESET = '{
        face: 1'b0, winding: 1'b0, mount_offset: 5'd0,
        extra_reverse: 1'b0, extra_offset: 5'd0, brightness: 9'd256
    };

    // One entry of the queue between the front and the back.
    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  ring;
        logic [10:0] render_index;
        ring_cfg_t   settings;
        logic [23:0] rgb;
    } cmd_t;

    // Handshake between the command queue and the back end.
    typedef struct packed {
        logic avail;
        cmd_t cmd;
    } cmd_head_t;

    // Reduce a value below 48 into the range of ring slots.
    function automatic logic [4:0] wrap_slot(input logic [5:0] v);
        logic [5:0] w;
        w = (v >= 6'(RING_LEDS)) ? (v - 6'(RING_LEDS)) : v;
        return w[4:0];
    endfunction

endpackage

[rtl/core/lrtr_front.sv]
// ----------------------------------------------------------------------------
// lrtr_front: request classifier
// Decides which accepted requests do work and normalizes their fields
// into a command for the back end.
// ----------------------------------------------------------------------------
module lrtr_front #(
    parameter int MAX_RINGS = lrtr_pkg::MAX_RINGS_DEF
) (
    input  lrtr_pkg::item_t item,
    input  logic [6:0]      ring_count,
    output logic            keep,
    output lrtr_pkg::cmd_t  cmd
);

    localparam logic [8:0]  MAX_RINGS_V = 9'(MAX_RINGS);
    localparam logic [12:0] DEPTH_V     = 13'(lrtr_pkg::RING_LEDS * MAX_RINGS);

    logic [8:0] limit;
    logic [8:0] ring_w;

    always_comb
    begin
        ring_w = {3'b000, item.ring};
        limit  = ({2'b00, ring_count} > MAX_RINGS_V) ? MAX_RINGS_V : {2'b00, ring_count};

        case (item.req_type)
            lrtr_pkg::REQ_SETTINGS: keep = (ring_w < MAX_RINGS_V);
            lrtr_pkg::REQ_PIXEL:    keep = ({2'b00, item.render_index} < DEPTH_V);
            lrtr_pkg::REQ_EMIT:     keep = (ring_w < limit);
            default:                keep = 1'b0;
        endcase

        cmd.kind                   = item.req_type;
        cmd.ring                   = item.ring;
        cmd.render_index           = item.render_index;
        cmd.settings.face          = item.face;
        cmd.settings.winding       = item.winding;
        cmd.settings.mount_offset  = lrtr_pkg::wrap_slot({1'b0, item.mount_offset});
        cmd.settings.extra_reverse = item.extra_reverse;
        cmd.settings.extra_offset  = lrtr_pkg::wrap_slot({1'b0, item.extra_offset});
        cmd.settings.brightness    = (item.brightness > 9'd256) ? 9'd256 : item.brightness;
        cmd.rgb                    = {item.red, item.green, item.blue};
    end

endmodule

[rtl/core/lrtr_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// lrtr_cmd_fifo: command queue
// Short queue that decouples request intake from ring processing.
// ----------------------------------------------------------------------------
module lrtr_cmd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  lrtr_pkg::cmd_t       wr_cmd,
    output logic                 full,
    input  logic                 rd_en,
    output lrtr_pkg::cmd_head_t  head
);

    localparam int DEPTH = lrtr_pkg::CMD_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    lrtr_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_wr, do_rd;

    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && (count_reg != '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign head.avail = (count_reg != '0);
    assign head.cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

[rtl/core/lrtr_back.sv]
// ----------------------------------------------------------------------------
// lrtr_back: ring processing engine
// Holds ring settings and the render store, carries out writes and walks
// the 24 slots of an emitted ring into a small result queue.
// ----------------------------------------------------------------------------
module lrtr_back #(
    parameter int MAX_RINGS = lrtr_pkg::MAX_RINGS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mirror_mode,
    input  lrtr_pkg::cmd_head_t head,
    output logic                cmd_pop,
    output lrtr_pkg::result_t   result,
    output logic                empty,
    input  logic                pop
);

    localparam int RW    = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
    localparam int RXW   = (RW > 6) ? RW : 6;
    localparam int DEPTH = lrtr_pkg::RING_LEDS * MAX_RINGS;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = (AW > 11) ? AW : 11;
    localparam int OD    = lrtr_pkg::OUT_DEPTH;
    localparam int OPW   = (OD > 1) ? $clog2(OD) : 1;
    localparam int OCW   = $clog2(OD + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SET  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    // Storage
    lrtr_pkg::ring_cfg_t set_mem [MAX_RINGS];
    logic [23:0]         pix_mem [DEPTH];
    logic [MAX_RINGS-1:0] set_valid_reg;

    // Sequencer
    logic [1:0]  state_reg, state_next;
    logic [5:0]  ring_reg;
    lrtr_pkg::ring_cfg_t set_rd_reg;
    logic        set_hit_reg;
    logic        rev_reg;
    logic [4:0]  shift_reg;
    logic [8:0]  bright_reg;
    logic [10:0] base_reg;
    logic [10:0] pidx_reg;
    logic [4:0]  slot_reg;

    // Read stage
    logic        s1_valid_reg;
    logic [10:0] s1_pidx_reg;
    logic        s1_last_reg;
    logic [8:0]  s1_bright_reg;
    logic [23:0] pix_rd_reg;

    // Result queue
    lrtr_pkg::result_t out_mem [OD];
    logic [OPW-1:0] out_wr_reg, out_rd_reg;
    logic [OCW-1:0] out_count_reg, out_count_next;

    logic [RXW-1:0] ring_x;
    logic [RW-1:0]  set_addr;
    logic [IW-1:0]  wr_idx_x;
    logic [AW-1:0]  wr_addr;
    lrtr_pkg::ring_cfg_t cfg_eff;
    logic        rev_new;
    logic [4:0]  shift_new;
    logic [10:0] ring_base;
    logic [4:0]  q;
    logic [4:0]  src_slot;
    logic [IW-1:0] rd_idx_x;
    logic [AW-1:0] rd_addr;
    logic        issue;
    logic        out_pop;
    logic [16:0] prod_r, prod_g, prod_b;
    lrtr_pkg::result_t s1_result;

    assign cmd_pop  = (state_reg == ST_IDLE) && head.avail;
    assign ring_x   = RXW'(head.cmd.ring);
    assign set_addr = ring_x[RW-1:0];
    assign wr_idx_x = IW'(head.cmd.render_index);
    assign wr_addr  = wr_idx_x[AW-1:0];

    always_comb
    begin
        cfg_eff   = set_hit_reg ? set_rd_reg : lrtr_pkg::RING_CFG_RESET;
        rev_new   = cfg_eff.face ^ cfg_eff.winding ^ (mirror_mode & cfg_eff.extra_reverse);
        shift_new = lrtr_pkg::wrap_slot({1'b0, cfg_eff.mount_offset}
                    + (mirror_mode ? {1'b0, cfg_eff.extra_offset} : 6'd0));
        ring_base = 11'({ring_reg, 4'b0000}) + 11'({ring_reg, 3'b000});

        q        = rev_reg ? (5'(lrtr_pkg::LAST_SLOT) - slot_reg) : slot_reg;
        src_slot = lrtr_pkg::wrap_slot({1'b0, q} + {1'b0, shift_reg});
        rd_idx_x = IW'(base_reg) + IW'(src_slot);
        rd_addr  = rd_idx_x[AW-1:0];

        // Issue only when the result queue has room for this pixel and
        // the one already in the read stage.
        issue = (state_reg == ST_RUN)
                && (({1'b0, out_count_reg} + {{OCW{1'b0}}, s1_valid_reg}) < (OCW + 1)'(OD));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_pop && (head.cmd.kind == lrtr_pkg::REQ_EMIT))
                begin
                    state_next = ST_SET;
                end
            end
            ST_SET:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (issue && (slot_reg == 5'(lrtr_pkg::LAST_SLOT)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Ring settings memory: one write port and one read port; every popped command reads it.
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            if (head.cmd.kind == lrtr_pkg::REQ_SETTINGS)
            begin
                set_mem[set_addr] <= head.cmd.settings;
            end
            set_rd_reg <= set_mem[set_addr];
        end
    end

    // Render store.
    always_ff @(posedge clk)
    begin
        if (cmd_pop && (head.cmd.kind == lrtr_pkg::REQ_PIXEL))
        begin
            pix_mem[wr_addr] <= head.cmd.rgb;
        end
        if (issue)
        begin
            pix_rd_reg <= pix_mem[rd_addr];
        end
    end

    // Per-slot payload of the sequencer and read stage.
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            ring_reg <= head.cmd.ring;
        end
        if (state_reg == ST_SET)
        begin
            rev_reg    <= rev_new;
            shift_reg  <= shift_new;
            bright_reg <= cfg_eff.brightness;
            base_reg   <= mirror_mode ? 11'd0 : ring_base;
        end
        if (issue)
        begin
            s1_pidx_reg   <= pidx_reg;
            s1_last_reg   <= (slot_reg == 5'(lrtr_pkg::LAST_SLOT));
            s1_bright_reg <= bright_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            set_valid_reg <= '0;
            set_hit_reg   <= 1'b0;
            slot_reg      <= '0;
            pidx_reg      <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            if (cmd_pop)
            begin
                set_hit_reg <= set_valid_reg[set_addr];
                if (head.cmd.kind == lrtr_pkg::REQ_SETTINGS)
                begin
                    set_valid_reg[set_addr] <= 1'b1;
                end
            end
            if (state_reg == ST_SET)
            begin
                slot_reg <= '0;
                pidx_reg <= ring_base;
            end
            else if (issue)
            begin
                slot_reg <= slot_reg + 1'b1;
                pidx_reg <= pidx_reg + 1'b1;
            end
        end
    end

    // Brightness scaling, in mirror mode only, on the way into the result queue.
    always_comb
    begin
        prod_r = 17'(pix_rd_reg[23:16]) * 17'(s1_bright_reg);
        prod_g = 17'(pix_rd_reg[15:8])  * 17'(s1_bright_reg);
        prod_b = 17'(pix_rd_reg[7:0])   * 17'(s1_bright_reg);
        s1_result.pixel_index  = s1_pidx_reg;
        s1_result.out_red      = mirror_mode ? prod_r[15:8] : pix_rd_reg[23:16];
        s1_result.out_green    = mirror_mode ? prod_g[15:8] : pix_rd_reg[15:8];
        s1_result.out_blue     = mirror_mode ? prod_b[15:8] : pix_rd_reg[7:0];
        s1_result.last_of_ring = s1_last_reg;
    end

    assign out_pop = pop && (out_count_reg != '0);
    assign empty   = (out_count_reg == '0);
    assign result  = out_mem[out_rd_reg];

    always_comb
    begin
        out_count_next = out_count_reg;
        if (s1_valid_reg && !out_pop)
        begin
            out_count_next = out_count_reg + 1'b1;
        end
        else if (out_pop && !s1_valid_reg)
        begin
            out_count_next = out_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            out_mem[out_wr_reg] <= s1_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            out_count_reg <= out_count_next;
            if (s1_valid_reg)
            begin
                out_wr_reg <= (out_wr_reg == OPW'(OD - 1)) ? '0 : out_wr_reg + 1'b1;
            end
            if (out_pop)
            begin
                out_rd_reg <= (out_rd_reg == OPW'(OD - 1)) ? '0 : out_rd_reg + 1'b1;
            end
        end
    end

endmodule

[rtl/core/led_ring_tiling_remap.sv]
// ----------------------------------------------------------------------------
// led_ring_tiling_remap: LED ring tiling remap, top level
// Maps a rendered frame onto a stack of 24-LED rings, with per-ring
// mounting correction and a mirror mode that copies ring 0 with scaling.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Payload
//   -------   -------------------------  ---------------------------------
//   request   push / full                item   (lrtr_pkg::item_t)
//   result    pop / empty                result (lrtr_pkg::result_t)
//   config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Settings and pixel writes are done as they are popped; an emit reads ring
// settings as it is popped, decodes them in the settings state, then walks
// its 24 slots through the render store's single read port and a read stage.
// Reset is asynchronous, active low; ring settings carry per-ring valid bits.
// A four-entry command queue and a four-entry result queue absorb stalls; the
// back end stops issuing reads whenever the result queue could overflow.
//
module led_ring_tiling_remap #(
    parameter int MAX_RINGS = lrtr_pkg::MAX_RINGS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  lrtr_pkg::item_t                     item,
    input  logic                                pop,
    output logic                                empty,
    output lrtr_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrtr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lrtr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                mirror_mode_reg;
    logic [6:0]          ring_count_reg;
    logic                keep;
    lrtr_pkg::cmd_t      front_cmd;
    lrtr_pkg::cmd_head_t head;
    logic                cmd_pop;

    // Configuration writes are taken every cycle; the user must send them only
    // while the block is idle; the block has no interlock that enforces this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_mode_reg <= 1'b0;
            ring_count_reg  <= 7'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lrtr_pkg::CFG_MIRROR_MODE: mirror_mode_reg <= cfg_data[0];
                lrtr_pkg::CFG_RING_COUNT:  ring_count_reg  <= cfg_data[6:0];
                default:                   ;
            endcase
        end
    end

    // Requests that do no work (unknown codes, out-of-range writes and
    // emits past the ring count) are accepted and dropped here.
    lrtr_front #(
        .MAX_RINGS (MAX_RINGS)
    ) u_front (
        .item       (item),
        .ring_count (ring_count_reg),
        .keep       (keep),
        .cmd        (front_cmd)
    );

    lrtr_cmd_fifo u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push && keep),
        .wr_cmd (front_cmd),
        .full   (full),
        .rd_en  (cmd_pop),
        .head   (head)
    );

    lrtr_back #(
        .MAX_RINGS (MAX_RINGS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .mirror_mode (mirror_mode_reg),
        .head        (head),
        .cmd_pop     (cmd_pop),
        .result      (result),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

[rtl/core/lrtr_checker.sv]
// ----------------------------------------------------------------------------
// lrtr_checker: port-level checks of the LED ring tiling remap
// Watches the result channel for ring framing and stall behavior.
// ----------------------------------------------------------------------------
module lrtr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              pop,
    input logic              empty,
    input lrtr_pkg::result_t result
);

    logic [4:0]  slot_reg;
    logic [10:0] prev_idx_reg;
    logic        taken;

    assign taken = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            prev_idx_reg <= '0;
        end
        else if (taken)
        begin
            slot_reg     <= result.last_of_ring ? 5'd0 : slot_reg + 1'b1;
            prev_idx_reg <= result.pixel_index;
        end
    end

    // Every ring is delivered as exactly 24 results, marked on the last.
    a_ring_framing: assert property (@(posedge clk) disable iff (!rst_n)
        taken |-> (result.last_of_ring == (slot_reg == 5'(lrtr_pkg::LAST_SLOT))))
        else $error("last_of_ring does not fall on the 24th pixel of a ring");

    // Within a ring, pixel positions run consecutively.
    a_ring_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (taken && (slot_reg != 5'd0)) |-> (result.pixel_index == prev_idx_reg + 11'd1))
        else $error("pixel_index is not consecutive within a ring");

    // A result that is not taken stays on the ports unchanged.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished before pop");

    // Nothing can be waiting in the first cycle after reset.
    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result channel not empty after reset");

endmodule

bind led_ring_tiling_remap lrtr_checker u_lrtr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);
